@@ src/mbps_pkg.sv @@
// shared constants, types and a helper function for the masked byte pattern scanner
package mbps_pkg;

  localparam int NUM_SIGS    = 4;
  localparam int MAX_SIG_LEN = 8;
  localparam int LEN_W       = 4;
  localparam int ADDR_W      = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIG0      = 3'd0,
    CFG_SIG1      = 3'd1,
    CFG_SIG2      = 3'd2,
    CFG_SIG3      = 3'd3,
    CFG_WILDCARDS = 3'd4,
    CFG_LENGTHS   = 3'd5,
    CFG_BASE      = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [NUM_SIGS-1:0][MAX_SIG_LEN*8-1:0] sig_bytes;
    logic [NUM_SIGS*8-1:0]                  wildcard_masks;
    logic [NUM_SIGS*LEN_W-1:0]              sig_lengths;
    logic [ADDR_W-1:0]                      base_address;
  } sig_cfg_t;

  // one scanned byte after matching: which signatures hit and the byte count
  typedef struct packed {
    logic [NUM_SIGS-1:0] hits;
    logic [ADDR_W-1:0]   count;
  } match_item_t;

  // effective length of signature k, clipped to the window depth
  function automatic logic [LEN_W-1:0] sig_len(input logic [NUM_SIGS*LEN_W-1:0] lens,
                                               input int k);
    logic [LEN_W-1:0] nib;
    nib = lens[LEN_W*k +: LEN_W];
    if (nib > LEN_W'(MAX_SIG_LEN)) begin
      return LEN_W'(MAX_SIG_LEN);
    end
    return nib;
  endfunction

endpackage

@@ src/mbps_byte_if.sv @@
// byte beat channel into the scanner
interface mbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_region;

  modport source (output valid, output data_byte, output first_of_region, input ready);
  modport sink (input valid, input data_byte, input first_of_region, output ready);
endinterface

@@ src/mbps_match_if.sv @@
// match result beat channel out of the scanner
interface mbps_match_if;
  logic                          valid;
  logic                          ready;
  logic [mbps_pkg::ADDR_W-1:0]   match_address;
  logic [1:0]                    sig_index;
  logic                          last_match;

  modport source (output valid, output match_address, output sig_index, output last_match,
                  input ready);
  modport sink (input valid, input match_address, input sig_index, input last_match,
                output ready);
endinterface

@@ src/mbps_window.sv @@
// byte window, region counters and parallel signature compare
module mbps_window (
  input  logic                   clk,
  input  logic                   rst,
  mbps_byte_if.sink              byte_in,
  input  mbps_pkg::sig_cfg_t     cfg,
  input  logic                   take_ok,
  output logic                   item_valid,
  output mbps_pkg::match_item_t  item
);

  logic [mbps_pkg::MAX_SIG_LEN-1:0][7:0] window;
  logic [mbps_pkg::MAX_SIG_LEN-1:0][7:0] window_next;
  logic [mbps_pkg::ADDR_W-1:0]           count;
  logic [mbps_pkg::ADDR_W-1:0]           count_next;
  logic [mbps_pkg::LEN_W-1:0]            fill;
  logic [mbps_pkg::LEN_W-1:0]            fill_next;
  logic [mbps_pkg::NUM_SIGS-1:0]         hits;
  logic                                  accept;

  assign byte_in.ready = take_ok;
  assign accept        = byte_in.valid & take_ok;

  // window, count and fill as they stand after this byte
  always_comb begin
    window_next[0] = byte_in.data_byte;
    for (int i = 1; i < mbps_pkg::MAX_SIG_LEN; i++) begin
      window_next[i] = byte_in.first_of_region ? 8'd0 : window[i-1];
    end
    count_next = (byte_in.first_of_region ? '0 : count) + mbps_pkg::ADDR_W'(1);
    if (byte_in.first_of_region) begin
      fill_next = mbps_pkg::LEN_W'(1);
    end else if (fill < mbps_pkg::LEN_W'(mbps_pkg::MAX_SIG_LEN)) begin
      fill_next = fill + mbps_pkg::LEN_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  // all signatures compared in parallel, byte j against window entry len-1-j
  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] len;
    logic                       hit;
    logic [2:0]                 pos;
    logic [7:0]                 want;
    for (int k = 0; k < mbps_pkg::NUM_SIGS; k++) begin
      len = mbps_pkg::sig_len(cfg.sig_lengths, k);
      hit = (len != '0) && (len <= fill_next);
      for (int j = 0; j < mbps_pkg::MAX_SIG_LEN; j++) begin
        pos  = 3'(len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(j));
        want = cfg.sig_bytes[k][8*j +: 8];
        if (mbps_pkg::LEN_W'(j) < len) begin
          if (!cfg.wildcard_masks[8*k+j] && (want != window_next[pos])) begin
            hit = 1'b0;
          end
        end
      end
      hits[k] = hit;
    end
  end

  assign item_valid = accept;
  assign item.hits  = hits;
  assign item.count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      count  <= '0;
      fill   <= '0;
    end else if (accept) begin
      window <= window_next;
      count  <= count_next;
      fill   <= fill_next;
    end
  end

endmodule

@@ src/mbps_emit.sv @@
// holds one byte's hits and sends them out one result beat at a time
module mbps_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  mbps_pkg::sig_cfg_t     cfg,
  input  logic                   item_valid,
  input  mbps_pkg::match_item_t  item,
  output logic                   take_ok,
  mbps_match_if.source           match_out
);

  logic [mbps_pkg::NUM_SIGS-1:0] hits;
  logic [mbps_pkg::NUM_SIGS-1:0] hits_left;
  logic [mbps_pkg::ADDR_W-1:0]   count;
  logic [1:0]                    sel;
  logic [mbps_pkg::LEN_W-1:0]    sel_len;
  logic                          move;
  logic                          out_valid;
  logic [mbps_pkg::ADDR_W-1:0]   out_address;
  logic [1:0]                    out_index;
  logic                          out_last;

  // lowest pending signature goes first
  always_comb begin
    sel = '0;
    for (int k = mbps_pkg::NUM_SIGS - 1; k >= 0; k--) begin
      if (hits[k]) begin
        sel = 2'(k);
      end
    end
    hits_left      = hits;
    hits_left[sel] = 1'b0;
  end

  assign sel_len = mbps_pkg::sig_len(cfg.sig_lengths, int'(sel));
  assign move    = !out_valid || match_out.ready;
  assign take_ok = (hits == '0) || (move && (hits_left == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (item_valid) begin
        hits <= item.hits;
      end else if (move) begin
        hits <= hits_left;
      end
      if (move) begin
        out_valid <= (hits != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      count <= item.count;
    end
    if (move) begin
      out_address <= cfg.base_address + (count - mbps_pkg::ADDR_W'(sel_len));
      out_index   <= sel;
      out_last    <= (hits_left == '0);
    end
  end

  assign match_out.valid         = out_valid;
  assign match_out.match_address = out_address;
  assign match_out.sig_index     = out_index;
  assign match_out.last_match    = out_last;

endmodule

@@ src/masked_byte_pattern_scanner_top.sv @@
// top level of the masked byte pattern scanner
//
// byte_in takes one byte of a scanned region per beat; first_of_region marks
// offset 0 and clears the byte window and the byte count. match_out gives one
// beat per signature hit: match_address is base_address plus the start offset,
// sig_index the signature slot, last_match flags the final hit of that byte.
// hits of one byte come in slot order; hits of different bytes in byte order.
// the configuration port writes one register per cycle while cfg_we is high;
// it is only to be written while no results are outstanding.
// a hit is held in the pending hits register, then in the output register.
// throughput: one byte per cycle while each byte causes at most one hit and
// match_out is not stalled; a byte with more hits holds the input until its
// last hit enters the single output register (one result per cycle).
// bytes with no hit produce no beat and never stall the input.
// a stall on match_out holds the output register and the pending hits; the
// input keeps flowing until a byte with hits is pending, then the next byte
// waits until the last of those hits moves into the output register.
// reset clears all configuration, the window, the count and pending results;
// bytes taken before any region mark count from offset 0.
module masked_byte_pattern_scanner_top (
  input  logic                                clk,
  input  logic                                rst,
  mbps_byte_if.sink                           byte_in,
  mbps_match_if.source                        match_out,
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mbps_pkg::sig_cfg_t    cfg;
  mbps_pkg::match_item_t item;
  logic                  item_valid;
  logic                  take_ok;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (mbps_pkg::cfg_index_t'(cfg_index))
        mbps_pkg::CFG_SIG0:      cfg.sig_bytes[0]  <= cfg_data;
        mbps_pkg::CFG_SIG1:      cfg.sig_bytes[1]  <= cfg_data;
        mbps_pkg::CFG_SIG2:      cfg.sig_bytes[2]  <= cfg_data;
        mbps_pkg::CFG_SIG3:      cfg.sig_bytes[3]  <= cfg_data;
        mbps_pkg::CFG_WILDCARDS: cfg.wildcard_masks <= cfg_data[mbps_pkg::NUM_SIGS*8-1:0];
        mbps_pkg::CFG_LENGTHS:
          cfg.sig_lengths <= cfg_data[mbps_pkg::NUM_SIGS*mbps_pkg::LEN_W-1:0];
        mbps_pkg::CFG_BASE:      cfg.base_address <= cfg_data[mbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // window update and compare, done in the cycle the byte is taken
  mbps_window u_window (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cfg        (cfg),
    .take_ok    (take_ok),
    .item_valid (item_valid),
    .item       (item)
  );

  // pending hits and the output register
  mbps_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take_ok    (take_ok),
    .match_out  (match_out)
  );

endmodule
